// File: hw/rtl/sha256_stream_hasher_unit_defines.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_defines
// Assertion macros used by the hasher back end (ssh_back).
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication
`define SSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam logic [3:0]  LEN_WORD    = 4'd14;  // word slot of the length field
  localparam logic [3:0]  LAST_WORD   = 4'd15;
  localparam logic [5:0]  LAST_BYTE   = 6'd63;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [2:0]  LAST_DIGEST = 3'd7;

  // one message word handed from front to back
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;   // word 15 of a block
    logic        last_blk;  // last block of the message
  } q_entry_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MARK, F_ZERO, F_LEN_HI, F_LEN_LO
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD, B_ROUND, B_ADD, B_EMIT
  } back_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] a);
    big_sig0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] e);
    big_sig1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic logic [31:0] sm_sig0(input logic [31:0] x);
    sm_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sm_sig1(input logic [31:0] x);
    sm_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_word(input logic [2:0] i);
    case (i)
      3'd0:    init_word = 32'h6a09e667;
      3'd1:    init_word = 32'hbb67ae85;
      3'd2:    init_word = 32'h3c6ef372;
      3'd3:    init_word = 32'ha54ff53a;
      3'd4:    init_word = 32'h510e527f;
      3'd5:    init_word = 32'h9b05688c;
      3'd6:    init_word = 32'h1f83d9ab;
      default: init_word = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

// File: hw/rtl/ssh_front.sv
// ----------------------------------------------------------------------------
// ssh_front
// Packs bytes into message words, counts length, generates padding.
// ----------------------------------------------------------------------------
module ssh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_end_of_message,
  input  logic              q_full,
  output logic              q_push,
  output ssh_pkg::q_entry_t q_data
);

  ssh_pkg::front_state_t state_r, state_nxt;
  logic [23:0] acc_r, acc_nxt;    // partial word, newest byte lowest
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] msg_r, msg_nxt;    // byte count
  logic [63:0] bit_len;
  logic [3:0]  wpos;
  logic [31:0] mark_word;
  logic        take;

  assign wpos     = fill_r[5:2];
  assign bit_len  = {msg_r[60:0], 3'b000};
  assign in_stall = (state_r != ssh_pkg::F_IDLE) || q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    case (fill_r[1:0])
      2'd0:    mark_word = {ssh_pkg::PAD_MARK, 24'h0};
      2'd1:    mark_word = {acc_r[7:0], ssh_pkg::PAD_MARK, 16'h0};
      2'd2:    mark_word = {acc_r[15:0], ssh_pkg::PAD_MARK, 8'h0};
      default: mark_word = {acc_r[23:0], ssh_pkg::PAD_MARK};
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssh_pkg::F_IDLE:   if (take && in_end_of_message) state_nxt = ssh_pkg::F_MARK;
      ssh_pkg::F_MARK:   if (!q_full) state_nxt = ssh_pkg::F_ZERO;
      ssh_pkg::F_ZERO: begin
        if (wpos == ssh_pkg::LEN_WORD) state_nxt = ssh_pkg::F_LEN_HI;
      end
      ssh_pkg::F_LEN_HI: if (!q_full) state_nxt = ssh_pkg::F_LEN_LO;
      ssh_pkg::F_LEN_LO: if (!q_full) state_nxt = ssh_pkg::F_IDLE;
      default:           state_nxt = ssh_pkg::F_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    acc_nxt = acc_r;
    fill_nxt = fill_r;
    msg_nxt = msg_r;
    q_push = 1'b0;
    q_data = '{word: 32'h0, blk_end: 1'b0, last_blk: 1'b0};
    case (state_r)
      ssh_pkg::F_IDLE: begin
        if (take && in_has_byte) begin
          acc_nxt  = {acc_r[15:0], in_data_byte};
          fill_nxt = fill_r + 6'd1;
          msg_nxt  = msg_r + 64'd1;
          if (fill_r[1:0] == 2'd3) begin
            q_push = 1'b1;
            q_data = '{word: {acc_r, in_data_byte},
                       blk_end: (fill_r == ssh_pkg::LAST_BYTE), last_blk: 1'b0};
          end
        end
      end
      ssh_pkg::F_MARK: begin
        if (!q_full) begin
          q_push   = 1'b1;
          q_data   = '{word: mark_word, blk_end: (wpos == ssh_pkg::LAST_WORD),
                       last_blk: 1'b0};
          fill_nxt = {wpos + 4'd1, 2'b00};
        end
      end
      ssh_pkg::F_ZERO: begin
        if (wpos != ssh_pkg::LEN_WORD && !q_full) begin
          q_push   = 1'b1;
          q_data   = '{word: 32'h0, blk_end: (wpos == ssh_pkg::LAST_WORD),
                       last_blk: 1'b0};
          fill_nxt = {wpos + 4'd1, 2'b00};
        end
      end
      ssh_pkg::F_LEN_HI: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data = '{word: bit_len[63:32], blk_end: 1'b0, last_blk: 1'b0};
        end
      end
      ssh_pkg::F_LEN_LO: begin
        if (!q_full) begin
          q_push   = 1'b1;
          q_data   = '{word: bit_len[31:0], blk_end: 1'b1, last_blk: 1'b1};
          fill_nxt = 6'd0;
          msg_nxt  = 64'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssh_pkg::F_IDLE;
      fill_r  <= 6'd0;
      msg_r   <= 64'd0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      msg_r   <= msg_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

// File: hw/rtl/ssh_queue.sv
// ----------------------------------------------------------------------------
// ssh_queue
// Short word queue between front and back.
// ----------------------------------------------------------------------------
module ssh_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssh_pkg::q_entry_t push_data,
  input  logic              pop,
  output ssh_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              empty
);

  ssh_pkg::q_entry_t mem_r [ssh_pkg::QUEUE_DEPTH];
  logic [ssh_pkg::QUEUE_AW-1:0] wr_r, rd_r;
  logic [ssh_pkg::QUEUE_AW:0]   cnt_r;

  assign full     = (cnt_r == ssh_pkg::QUEUE_AW'(0) + (ssh_pkg::QUEUE_AW+1)'(ssh_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (ssh_pkg::QUEUE_AW+1)'(push) - (ssh_pkg::QUEUE_AW+1)'(pop);
    end
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// File: hw/rtl/ssh_back.sv
// ----------------------------------------------------------------------------
// ssh_back
// Loads 16-word blocks, runs one compression round per cycle, emits digest.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_unit_defines.svh"

module ssh_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ssh_pkg::q_entry_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  ssh_pkg::back_state_t state_r, state_nxt;
  logic [31:0] w_r     [16];   // schedule window, w_r[0] is current word
  logic [31:0] w_nxt   [16];
  logic [31:0] v_r     [8];    // working variables a..h
  logic [31:0] v_nxt   [8];
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        final_r, final_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [2:0]  oi_r, oi_nxt;
  logic        ol_r, ol_nxt;
  logic [31:0] t1, t2, w_new, ch, maj;
  logic        out_free;

  assign out_free = !ov_r || !out_stall;
  assign q_pop    = (state_r == ssh_pkg::B_LOAD) && !q_empty;

  assign ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1    = v_r[7] + ssh_pkg::big_sig1(v_r[4]) + ch + ssh_pkg::round_k(rnd_r) + w_r[0];
  assign t2    = ssh_pkg::big_sig0(v_r[0]) + maj;
  assign w_new = ssh_pkg::sm_sig1(w_r[14]) + w_r[9] + ssh_pkg::sm_sig0(w_r[1]) + w_r[0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssh_pkg::B_LOAD:  if (q_pop && q_data.blk_end) state_nxt = ssh_pkg::B_ROUND;
      ssh_pkg::B_ROUND: if (rnd_r == ssh_pkg::LAST_ROUND) state_nxt = ssh_pkg::B_ADD;
      ssh_pkg::B_ADD:   state_nxt = final_r ? ssh_pkg::B_EMIT : ssh_pkg::B_LOAD;
      ssh_pkg::B_EMIT: begin
        if (out_free && idx_r == ssh_pkg::LAST_DIGEST) state_nxt = ssh_pkg::B_LOAD;
      end
      default:          state_nxt = ssh_pkg::B_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    w_nxt     = w_r;
    v_nxt     = v_r;
    chain_nxt = chain_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    final_nxt = final_r;
    ov_nxt    = ov_r && out_stall;
    ow_nxt    = ow_r;
    oi_nxt    = oi_r;
    ol_nxt    = ol_r;
    case (state_r)
      ssh_pkg::B_LOAD: begin
        if (q_pop) begin
          for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
          w_nxt[15] = q_data.word;
          if (q_data.blk_end) begin
            v_nxt     = chain_r;
            rnd_nxt   = 6'd0;
            final_nxt = q_data.last_blk;
          end
        end
      end
      ssh_pkg::B_ROUND: begin
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = w_new;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
      end
      ssh_pkg::B_ADD: begin
        for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + v_r[i];
        idx_nxt = 3'd0;
      end
      ssh_pkg::B_EMIT: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          ow_nxt  = chain_r[idx_r];
          oi_nxt  = idx_r;
          ol_nxt  = (idx_r == ssh_pkg::LAST_DIGEST);
          idx_nxt = idx_r + 3'd1;
          if (idx_r == ssh_pkg::LAST_DIGEST) begin
            for (int i = 0; i < 8; i++) chain_nxt[i] = ssh_pkg::init_word(3'(i));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssh_pkg::B_LOAD;
      ov_r    <= 1'b0;
      final_r <= 1'b0;
      rnd_r   <= 6'd0;
      idx_r   <= 3'd0;
      for (int i = 0; i < 8; i++) chain_r[i] <= ssh_pkg::init_word(3'(i));
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      final_r <= final_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      chain_r <= chain_nxt;
    end
    w_r  <= w_nxt;
    v_r  <= v_nxt;
    ow_r <= ow_nxt;
    oi_r <= oi_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_digest_word = ow_r;
  assign out_word_index  = oi_r;
  assign out_last_word   = ol_r;

  `SSH_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "pop from empty queue")
  `SSH_ASSERT_NEXT(a_round_end, (state_r == ssh_pkg::B_ROUND && rnd_r == ssh_pkg::LAST_ROUND), (state_r == ssh_pkg::B_ADD), "round 63 not followed by add")
  `SSH_ASSERT_NOW(a_last_idx, (ov_r && ol_r), (oi_r == ssh_pkg::LAST_DIGEST), "last flag off index 7")

endmodule

// File: hw/rtl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: one word per accepted item (in_valid high, in_stall low):
//   a message byte when in_has_byte is set, and in_end_of_message closing
//   the message (after its byte, if any). Empty messages are fine.
// Output channel: eight words per message, index 0 (most significant) to 7,
//   out_last_word set on index 7. Held stable while out_stall is high.
// Front packs bytes into 32-bit words and builds padding and length words;
//   a 4-entry queue separates it from the back end, which loads 16 words
//   then runs 64 rounds, one round per cycle, and then folds the working
//   variables into the chaining words.
// Throughput: bytes go in at one per cycle until the queue fills. The queue
//   takes 16 bytes while the back end runs the rounds and the fold; the other
//   48 bytes of the block then come in at one per cycle, so input stalls for
//   each 64-byte block while the back end compresses it.
// After end of message the back end compresses the padded last block, or two
//   blocks when padding spills into a second one; digest words then come out
//   one per cycle unless stalled.
// Reset (synchronous, rst_n low) returns the initial hash value, clears the
//   byte count and empties the queue and output register.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  ssh_pkg::q_entry_t push_data, pop_data;
  logic push, pop, full, empty;

  // byte packer and padding generator
  ssh_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (full),
    .q_push            (push),
    .q_data            (push_data)
  );

  // decoupling queue
  ssh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // compression engine and digest output register
  ssh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
